FILE: rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// Stream loss and latency tracker package
// Shared types and constants for the front, back and top-level modules.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int SEQ_W      = 16;
    localparam int REMOTE_W   = 32;
    localparam int LOCAL_W    = 40;
    localparam int COUNT_W    = 32;
    localparam int DELTA_W    = 42;
    localparam int WLEN_W     = 16;
    localparam int GAP_W      = 15;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic CFG_WINDOW_LENGTH = 1'b0;
    localparam logic CFG_GAP_LIMIT     = 1'b1;

    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 16'd10000;
    localparam logic [GAP_W-1:0]  GAP_LIMIT_RESET     = 15'd100;

    // Largest positive 42-bit signed value restarts the minimum tracker.
    localparam logic signed [DELTA_W-1:0] MIN_DELTA_RESET = {1'b0, {(DELTA_W-1){1'b1}}};

    // Moving average: avg = (avg * 9 + excess) / 10. For any 32-bit x,
    // x / 10 is the product x * TENTH_RECIP shifted right by TENTH_SHIFT.
    localparam logic [COUNT_W-1:0] TENTH_RECIP = 32'hCCCC_CCCD;
    localparam int                 TENTH_SHIFT = 35;

    typedef struct packed {
        logic [WLEN_W-1:0] window_length_ms;
        logic [GAP_W-1:0]  gap_limit;
    } t_cfg;

    // One classified frame travelling from the front to the back.
    typedef struct packed {
        logic                       has_time;
        logic                       restart;
        logic signed [DELTA_W-1:0]  delta;
        logic [COUNT_W-1:0]         received;
        logic [COUNT_W-1:0]         dropped;
    } t_work;

    typedef struct packed {
        logic [COUNT_W-1:0] received_count;
        logic [COUNT_W-1:0] dropped_count;
        logic [COUNT_W-1:0] latency_estimate_ms;
    } t_result;

endpackage

FILE: rtl/slt_fifo.sv
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer with the head visible while not empty.
// ----------------------------------------------------------------------------
module slt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/slt_front.sv
// ----------------------------------------------------------------------------
// Frame classifier
// Updates the frame counters and the window clock, and forms the delay.
// ----------------------------------------------------------------------------
module slt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slt_pkg::t_cfg                 i_cfg,
    input  logic                          i_accept,
    input  logic [slt_pkg::SEQ_W-1:0]     i_sequence_req,
    input  logic [slt_pkg::REMOTE_W-1:0]  i_remote_time_ms,
    input  logic [slt_pkg::LOCAL_W-1:0]   i_local_time_ms,
    input  logic                          i_frame_accepted,
    output slt_pkg::t_work                o_work
);

    logic                              r_seen_first;
    logic [slt_pkg::SEQ_W-1:0]         r_prev_seq;
    logic [slt_pkg::COUNT_W-1:0]       r_dropped, n_dropped;
    logic [slt_pkg::COUNT_W-1:0]       r_received, n_received;
    logic [slt_pkg::LOCAL_W-1:0]       r_window_start;

    logic [slt_pkg::SEQ_W-1:0]         expected;
    logic [slt_pkg::SEQ_W-1:0]         diff;
    logic                              is_drop;
    logic                              has_time;
    logic [slt_pkg::LOCAL_W-1:0]       elapsed;
    logic                              restart;

    // A forward gap is a difference in 1..32767 that stays below the limit.
    assign expected = r_prev_seq + 1'b1;
    assign diff     = i_sequence_req - expected;
    assign is_drop  = r_seen_first && (diff != '0) && !diff[slt_pkg::SEQ_W-1]
                      && (diff[slt_pkg::GAP_W-1:0] < i_cfg.gap_limit);

    assign n_dropped  = is_drop ? r_dropped + slt_pkg::COUNT_W'(diff) : r_dropped;
    assign n_received = r_received + slt_pkg::COUNT_W'(i_frame_accepted);

    assign has_time = (i_remote_time_ms != '0);
    assign elapsed  = i_local_time_ms - r_window_start;
    assign restart  = (elapsed > slt_pkg::LOCAL_W'(i_cfg.window_length_ms));

    always_comb begin
        o_work.has_time = has_time;
        o_work.restart  = restart;
        o_work.delta    = $signed(slt_pkg::DELTA_W'(i_local_time_ms))
                          - $signed(slt_pkg::DELTA_W'(i_remote_time_ms));
        o_work.received = n_received;
        o_work.dropped  = n_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first   <= 1'b0;
            r_prev_seq     <= '0;
            r_dropped      <= '0;
            r_received     <= '0;
            r_window_start <= '0;
        end else if (i_accept) begin
            r_seen_first <= 1'b1;
            r_prev_seq   <= i_sequence_req;
            r_dropped    <= n_dropped;
            r_received   <= n_received;
            if (has_time && restart) begin
                r_window_start <= i_local_time_ms;
            end
        end
    end

endmodule

FILE: rtl/slt_back.sv
// ----------------------------------------------------------------------------
// Latency engine
// Tracks the windowed minimum delay and the smoothed excess over it.
// ----------------------------------------------------------------------------
module slt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slt_pkg::t_work   i_work,
    input  logic             i_work_empty,
    output logic             o_work_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output slt_pkg::t_result o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIFF = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int CW = slt_pkg::COUNT_W;
    localparam int PW = 2 * slt_pkg::COUNT_W;

    logic [1:0]                          r_state;
    logic signed [slt_pkg::DELTA_W-1:0]  r_min;
    logic [CW-1:0]                       r_smooth;
    logic [CW-1:0]                       r_excess;
    logic [CW-1:0]                       r_received;
    logic [CW-1:0]                       r_dropped;
    logic [CW-1:0]                       r_diff;
    logic                                r_below;
    logic [CW-1:0]                       r_tenth;

    logic                                take;
    logic                                lower;
    logic [slt_pkg::DELTA_W-1:0]         excess_full;
    logic [CW-1:0]                       excess_sat;
    logic                                below;
    logic [CW-1:0]                       spread;
    logic [PW-1:0]                       product;
    logic [CW+2:0]                       tenfold;
    logic                                inexact;
    logic [CW-1:0]                       smooth_next;

    assign take = (r_state == ST_IDLE) && !i_work_empty && !i_res_full;
    assign o_work_pop = take;

    // A new minimum either comes from a window restart or a smaller delay;
    // in both cases the excess is zero.
    assign lower       = i_work.restart || (i_work.delta < r_min);
    assign excess_full = lower ? '0 : slt_pkg::DELTA_W'(i_work.delta - r_min);
    assign excess_sat  = (excess_full[slt_pkg::DELTA_W-1:slt_pkg::COUNT_W] != '0)
                         ? '1 : excess_full[slt_pkg::COUNT_W-1:0];

    // (9 * avg + excess) / 10 is avg + (excess - avg) / 10 when the excess is
    // not below the average, and avg minus the rounded-up tenth of
    // (avg - excess) otherwise, so only a 32-bit tenth is ever needed.
    assign below  = (r_excess < r_smooth);
    assign spread = below ? r_smooth - r_excess : r_excess - r_smooth;

    // Reciprocal multiply gives the truncated tenth of the spread.
    assign product = PW'(r_diff) * PW'(slt_pkg::TENTH_RECIP);

    // When the excess is below the average, the tenth is rounded up when ten times it falls short of the spread.
    assign tenfold     = {r_tenth, 3'b000} + {2'b00, r_tenth, 1'b0};
    assign inexact     = (tenfold != {3'b000, r_diff});
    assign smooth_next = r_below ? r_smooth - r_tenth - CW'(inexact)
                                 : r_smooth + r_tenth;

    always_comb begin
        o_res_push = 1'b0;
        o_result.received_count      = i_work.received;
        o_result.dropped_count       = i_work.dropped;
        o_result.latency_estimate_ms = r_smooth;
        if (take && !i_work.has_time) begin
            o_res_push = 1'b1;
        end else if (r_state == ST_DONE) begin
            o_res_push = 1'b1;
            o_result.received_count      = r_received;
            o_result.dropped_count       = r_dropped;
            o_result.latency_estimate_ms = smooth_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_min    <= slt_pkg::MIN_DELTA_RESET;
            r_smooth <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (take && i_work.has_time) begin
                        r_min   <= lower ? i_work.delta : r_min;
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_smooth <= smooth_next;
                    r_state  <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_excess   <= excess_sat;
            r_received <= i_work.received;
            r_dropped  <= i_work.dropped;
        end
        if (r_state == ST_DIFF) begin
            r_diff  <= spread;
            r_below <= below;
        end
        if (r_state == ST_MUL) begin
            r_tenth <= CW'(product >> slt_pkg::TENTH_SHIFT);
        end
    end

endmodule

FILE: rtl/stream_loss_latency_tracker.sv
// ----------------------------------------------------------------------------
// Stream loss and latency tracker
// Counts received and lost audio frames and smooths the delay above a
// windowed minimum, giving one result transaction per frame transaction.
// ----------------------------------------------------------------------------
// Path: a frame without a sender timestamp goes into the result queue when the
// back takes it; a timestamped frame first passes the difference, reciprocal
// multiply and rounding steps. Throughput: one frame per cycle without timestamp
// while the result queue has room; the back takes no new frame during those steps.
// Reset (i_rst_n low at a clock edge) empties both queues, clears all
// counters and restores the register defaults (window 10000 ms, limit 100).
// ----------------------------------------------------------------------------
module stream_loss_latency_tracker #(
    parameter int WORK_DEPTH   = 4,
    parameter int RESULT_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_wr_en,
    input  logic                               i_cfg_index,
    input  logic [slt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Frame transactions.
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [slt_pkg::SEQ_W-1:0]          i_sequence_req,
    input  logic [slt_pkg::REMOTE_W-1:0]       i_remote_time_ms,
    input  logic [slt_pkg::LOCAL_W-1:0]        i_local_time_ms,
    input  logic                               i_frame_accepted,
    // Result transactions.
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic [slt_pkg::COUNT_W-1:0]        o_received_count,
    output logic [slt_pkg::COUNT_W-1:0]        o_dropped_count,
    output logic [slt_pkg::COUNT_W-1:0]        o_latency_estimate_ms
);

    localparam int WORK_W   = $bits(slt_pkg::t_work);
    localparam int RESULT_W = $bits(slt_pkg::t_result);

    slt_pkg::t_cfg    r_cfg;
    slt_pkg::t_work   front_work;
    slt_pkg::t_work   back_work;
    slt_pkg::t_result back_result;
    slt_pkg::t_result head_result;
    logic             accept;
    logic             work_empty;
    logic             work_pop;
    logic             res_full;
    logic             res_push;

    // Configuration registers. Writes must arrive only while the block is idle, which
    // the block itself does not enforce; then they take effect with no ordering concerns.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length_ms <= slt_pkg::WINDOW_LENGTH_RESET;
            r_cfg.gap_limit        <= slt_pkg::GAP_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                slt_pkg::CFG_WINDOW_LENGTH: begin
                    r_cfg.window_length_ms <= i_cfg_data;
                end
                slt_pkg::CFG_GAP_LIMIT: begin
                    r_cfg.gap_limit <= i_cfg_data[slt_pkg::GAP_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // A frame transaction is taken whenever the work queue has room. The
    // front updates the loss counters and the window clock in that cycle.
    assign accept = i_push && !o_full;

    slt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_accept         (accept),
        .i_sequence_req   (i_sequence_req),
        .i_remote_time_ms (i_remote_time_ms),
        .i_local_time_ms  (i_local_time_ms),
        .i_frame_accepted (i_frame_accepted),
        .o_work           (front_work)
    );

    // The work queue lets the front keep accepting frames while the back is
    // busy dividing for a timestamped frame.
    slt_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (WORK_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_work),
        .o_full  (o_full),
        .i_pop   (work_pop),
        .o_empty (work_empty),
        .o_data  (back_work)
    );

    // The back owns the minimum delay and the moving average.
    slt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (back_work),
        .i_work_empty (work_empty),
        .o_work_pop   (work_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_result     (back_result)
    );

    // Finished results wait here so a stalled consumer does not stop the back until the queue is full.
    slt_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (head_result)
    );

    assign o_received_count      = head_result.received_count;
    assign o_dropped_count       = head_result.dropped_count;
    assign o_latency_estimate_ms = head_result.latency_estimate_ms;

endmodule

FILE: test/slt_frame_checker.sv
// ----------------------------------------------------------------------------
// Frame statistics checker
// Watches the configuration port and both queue sides of the tracker. It
// predicts the counters and the latency estimate of every accepted frame and
// compares each popped result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module slt_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_index,
    input  logic [slt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_push,
    input  logic                            i_full,
    input  logic [slt_pkg::SEQ_W-1:0]       i_sequence_req,
    input  logic [slt_pkg::REMOTE_W-1:0]    i_remote_time_ms,
    input  logic [slt_pkg::LOCAL_W-1:0]     i_local_time_ms,
    input  logic                            i_frame_accepted,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  logic [slt_pkg::COUNT_W-1:0]     i_received_count,
    input  logic [slt_pkg::COUNT_W-1:0]     i_dropped_count,
    input  logic [slt_pkg::COUNT_W-1:0]     i_latency_estimate_ms,
    output int                              o_mismatches,
    output int                              o_outstanding,
    output int                              o_compared
);

    logic [slt_pkg::WLEN_W-1:0]         window_len;
    logic [slt_pkg::GAP_W-1:0]          gap_limit;
    logic                               have_prev;
    logic [slt_pkg::SEQ_W-1:0]          prior_seq;
    logic [slt_pkg::COUNT_W-1:0]        lost_frames;
    logic [slt_pkg::COUNT_W-1:0]        taken_frames;
    logic signed [slt_pkg::DELTA_W-1:0] floor_delta;
    logic [slt_pkg::LOCAL_W-1:0]        window_origin;
    logic [slt_pkg::COUNT_W-1:0]        avg_excess;

    slt_pkg::t_result expected_stats[$];

    int mismatches = 0;
    int compared   = 0;
    int outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;
    assign o_compared    = compared;

    // Updates the tracked statistics with one frame and returns the counters
    // and the estimate that the block must report for it.
    task automatic advance_stats(
        input  logic [slt_pkg::SEQ_W-1:0]    seq,
        input  logic [slt_pkg::REMOTE_W-1:0] remote,
        input  logic [slt_pkg::LOCAL_W-1:0]  arrival,
        input  logic                         accepted,
        output slt_pkg::t_result             stats
    );
        logic [slt_pkg::SEQ_W-1:0]          next_seq;
        logic [slt_pkg::SEQ_W-1:0]          seq_gap;
        logic signed [slt_pkg::DELTA_W-1:0] delta;
        logic signed [slt_pkg::DELTA_W-1:0] above_floor;
        logic [slt_pkg::LOCAL_W-1:0]        elapsed;
        logic [63:0]                        excess;
        logic [63:0]                        blend;

        if (have_prev) begin
            next_seq = prior_seq + 16'd1;
            seq_gap  = seq - next_seq;
            // Only a forward gap (positive as a signed 16-bit value) below the
            // limit is taken as lost frames.
            if (seq_gap != 16'd0 && seq_gap <= 16'h7FFF && seq_gap < {1'b0, gap_limit}) begin
                lost_frames = lost_frames + {16'd0, seq_gap};
            end
        end
        have_prev = 1'b1;
        prior_seq = seq;

        if (remote != '0) begin
            delta   = $signed({2'b00, arrival}) - $signed({10'd0, remote});
            elapsed = arrival - window_origin;
            if (elapsed > {24'd0, window_len}) begin
                floor_delta   = delta;
                window_origin = arrival;
            end
            if (delta < floor_delta) begin
                floor_delta = delta;
            end
            above_floor = delta - floor_delta;
            excess      = {22'd0, above_floor};
            if (excess > 64'hFFFF_FFFF) begin
                excess = 64'hFFFF_FFFF;
            end
            blend      = ({32'd0, avg_excess} * 64'd9 + excess) / 64'd10;
            avg_excess = blend[31:0];
        end

        if (accepted) begin
            taken_frames = taken_frames + 32'd1;
        end

        stats.received_count      = taken_frames;
        stats.dropped_count       = lost_frames;
        stats.latency_estimate_ms = avg_excess;
    endtask

    task automatic check_field(
        input string                       field,
        input logic [slt_pkg::COUNT_W-1:0] want,
        input logic [slt_pkg::COUNT_W-1:0] got
    );
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        slt_pkg::t_result want;

        if (!i_rst_n) begin
            window_len    = slt_pkg::WINDOW_LENGTH_RESET;
            gap_limit     = slt_pkg::GAP_LIMIT_RESET;
            have_prev     = 1'b0;
            prior_seq     = '0;
            lost_frames   = '0;
            taken_frames  = '0;
            floor_delta   = slt_pkg::MIN_DELTA_RESET;
            window_origin = '0;
            avg_excess    = '0;
            expected_stats.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    slt_pkg::CFG_WINDOW_LENGTH: window_len = i_cfg_data[slt_pkg::WLEN_W-1:0];
                    slt_pkg::CFG_GAP_LIMIT:     gap_limit  = i_cfg_data[slt_pkg::GAP_W-1:0];
                    default: ;
                endcase
            end
            // A result always trails its frame by cycles, so the pop side is
            // matched before this edge's frame is predicted.
            if (i_pop && !i_empty) begin
                if (expected_stats.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transaction with nothing expected: %0d %0d %0d",
                             $time, i_received_count, i_dropped_count,
                             i_latency_estimate_ms);
                end else begin
                    want = expected_stats.pop_front();
                    check_field("received_count", want.received_count, i_received_count);
                    check_field("dropped_count", want.dropped_count, i_dropped_count);
                    check_field("latency_estimate_ms", want.latency_estimate_ms,
                                i_latency_estimate_ms);
                    compared++;
                end
            end
            if (i_push && !i_full) begin
                advance_stats(i_sequence_req, i_remote_time_ms, i_local_time_ms,
                              i_frame_accepted, want);
                expected_stats.push_back(want);
            end
        end
        outstanding = expected_stats.size();
    end

endmodule

FILE: test/stream_loss_latency_tracker_tb.sv
// ----------------------------------------------------------------------------
// Stream loss and latency tracker testbench
// Drives frame transactions and register writes into the tracker, pops the
// results with random stalls, and leaves prediction and comparison to the
// frame statistics checker that sits beside the block.
// ----------------------------------------------------------------------------
module stream_loss_latency_tracker_tb;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_wr_en;
    logic                            i_cfg_index;
    logic [slt_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            i_push;
    logic                            o_full;
    logic [slt_pkg::SEQ_W-1:0]       i_sequence_req;
    logic [slt_pkg::REMOTE_W-1:0]    i_remote_time_ms;
    logic [slt_pkg::LOCAL_W-1:0]     i_local_time_ms;
    logic                            i_frame_accepted;
    logic                            o_empty;
    logic                            i_pop;
    logic [slt_pkg::COUNT_W-1:0]     o_received_count;
    logic [slt_pkg::COUNT_W-1:0]     o_dropped_count;
    logic [slt_pkg::COUNT_W-1:0]     o_latency_estimate_ms;

    int mismatches;
    int outstanding;
    int compared;

    // When set, neither side idles: frames go in back to back and results
    // are popped as soon as they show up.
    bit quiet = 1'b0;

    int frames_sent = 0;
    int settings_used = 1;

    // Tracking of the current stream so that random frames can follow a
    // plausible sequence and clock instead of pure noise.
    logic [slt_pkg::WLEN_W-1:0]   window_now = slt_pkg::WINDOW_LENGTH_RESET;
    logic [slt_pkg::GAP_W-1:0]    gap_now    = slt_pkg::GAP_LIMIT_RESET;
    logic [slt_pkg::SEQ_W-1:0]    seq_cursor;
    logic [slt_pkg::LOCAL_W-1:0]  clock_ms;
    logic [slt_pkg::REMOTE_W-1:0] sender_offset;

    stream_loss_latency_tracker uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_push                (i_push),
        .o_full                (o_full),
        .i_sequence_req        (i_sequence_req),
        .i_remote_time_ms      (i_remote_time_ms),
        .i_local_time_ms       (i_local_time_ms),
        .i_frame_accepted      (i_frame_accepted),
        .o_empty               (o_empty),
        .i_pop                 (i_pop),
        .o_received_count      (o_received_count),
        .o_dropped_count       (o_dropped_count),
        .o_latency_estimate_ms (o_latency_estimate_ms)
    );

    slt_frame_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_push                (i_push),
        .i_full                (o_full),
        .i_sequence_req        (i_sequence_req),
        .i_remote_time_ms      (i_remote_time_ms),
        .i_local_time_ms       (i_local_time_ms),
        .i_frame_accepted      (i_frame_accepted),
        .i_empty               (o_empty),
        .i_pop                 (i_pop),
        .i_received_count      (o_received_count),
        .i_dropped_count       (o_dropped_count),
        .i_latency_estimate_ms (o_latency_estimate_ms),
        .o_mismatches          (mismatches),
        .o_outstanding         (outstanding),
        .o_compared            (compared)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle lengths: none more than half the time, otherwise a random idle from
    // one of three ranges; the longest lets the queues on either side fill up or run dry.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Keeps push low for the given number of cycles. Each cycle is its own
    // falling edge, so push is never lowered and raised in one time step.
    task automatic push_idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_push <= 1'b0;
        end
    endtask

    // Presents one frame and holds it until the block takes it. Full is read
    // right at the rising edge, before the block updates it for the next one.
    task automatic send_frame(
        input logic [slt_pkg::SEQ_W-1:0]    seq,
        input logic [slt_pkg::REMOTE_W-1:0] remote,
        input logic [slt_pkg::LOCAL_W-1:0]  arrival,
        input logic                         accepted
    );
        @(negedge i_clk);
        i_push           <= 1'b1;
        i_sequence_req   <= seq;
        i_remote_time_ms <= remote;
        i_local_time_ms  <= arrival;
        i_frame_accepted <= accepted;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        frames_sent++;
        if (!quiet) begin
            push_idle(pick_gap());
        end
    endtask

    // Every frame produces exactly one result, so once the checker holds no
    // expectation the block has nothing in flight.
    task automatic wait_drained();
        push_idle(1);
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(
        input logic                           index,
        input logic [slt_pkg::CFG_DATA_W-1:0] data
    );
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (index == slt_pkg::CFG_WINDOW_LENGTH) begin
            window_now = data[slt_pkg::WLEN_W-1:0];
        end else begin
            gap_now = data[slt_pkg::GAP_W-1:0];
        end
    endtask

    // One random frame. Most follow the running stream: the sequence steps
    // forward, sometimes skipping frames or jumping right around the gap
    // limit, and the clock advances, sometimes exactly across the window edge.
    // The rest are broken frames (repeats, backward sequences, a clock that
    // runs back) and plain noise over the whole field ranges.
    task automatic random_frame();
        int                           kind;
        int                           roll;
        logic [slt_pkg::SEQ_W-1:0]    seq;
        logic [slt_pkg::REMOTE_W-1:0] remote;
        logic [slt_pkg::LOCAL_W-1:0]  arrival;

        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                seq_cursor = seq_cursor + 16'd1;
            end else if (roll < 90) begin
                seq_cursor = seq_cursor + 16'($urandom_range(2, 6));
            end else begin
                seq_cursor = seq_cursor + {1'b0, gap_now} + 16'($urandom_range(0, 2));
            end
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                clock_ms = clock_ms + 40'($urandom_range(0, 40));
            end else if (roll < 95) begin
                clock_ms = clock_ms + {24'd0, window_now} + 40'($urandom_range(0, 1));
            end else begin
                clock_ms = clock_ms + 40'($urandom_range(1000, 100000));
            end
            remote = clock_ms[31:0] - sender_offset - 32'($urandom_range(0, 300));
            if ($urandom_range(0, 9) == 0) begin
                remote = '0;
            end
            send_frame(seq_cursor, remote, clock_ms, $urandom_range(0, 7) != 0);
        end else if (kind < 85) begin
            seq     = seq_cursor - 16'($urandom_range(0, 3));
            arrival = clock_ms - 40'($urandom_range(1, 5000));
            remote  = ($urandom_range(0, 1) == 0) ? '0 : arrival[31:0] - sender_offset;
            send_frame(seq, remote, arrival, 1'($urandom_range(0, 1)));
        end else begin
            arrival = 40'({$urandom, $urandom});
            send_frame(16'($urandom), $urandom, arrival, 1'($urandom_range(0, 1)));
        end
    endtask

    // Result side: pop for a cycle, then stall for a random stretch, unless
    // the current phase runs without idling.
    initial begin : pop_driver
        int hold;
        hold  = 0;
        i_pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold > 0 && !quiet) begin
                i_pop <= 1'b0;
                hold--;
            end else begin
                i_pop <= 1'b1;
                hold = quiet ? 0 : pick_gap();
            end
        end
    end

    initial begin : stimulus
        logic [slt_pkg::CFG_DATA_W-1:0] window_data;
        logic [slt_pkg::CFG_DATA_W-1:0] gap_data;

        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_index      = slt_pkg::CFG_WINDOW_LENGTH;
        i_cfg_data       = '0;
        i_push           = 1'b0;
        i_sequence_req   = '0;
        i_remote_time_ms = '0;
        i_local_time_ms  = '0;
        i_frame_accepted = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset settings (window 10000, limit 100).
        // The first frame only records its sequence number; the second wraps
        // the sequence to zero and sets the first minimum.
        send_frame(16'hFFFF, 32'd0, 40'd0, 1'b1);
        send_frame(16'h0000, 32'd1, 40'd1000, 1'b0);
        // Four frames lost, and a delay 51 ms above the minimum.
        send_frame(16'd5, 32'd1000, 40'd2050, 1'b1);
        // A repeated and then a backward sequence count nothing; neither has
        // a timestamp, so the latency tracking stays as it is.
        send_frame(16'd5, 32'd0, 40'd2100, 1'b1);
        send_frame(16'd3, 32'd0, 40'd2200, 1'b0);
        // A gap one below the limit counts, a gap equal to the limit does not.
        send_frame(16'd103, 32'd2000, 40'd2500, 1'b1);
        send_frame(16'd204, 32'd2100, 40'd2600, 1'b1);
        // A gap of half the sequence space is backward. The largest sender
        // time at local time zero gives the most negative delay.
        send_frame(16'h80CD, 32'hFFFF_FFFF, 40'd0, 1'b1);
        // Within the window, the excess over that minimum no longer fits in
        // 32 bits and must saturate.
        send_frame(16'h80CE, 32'd1, 40'd5000, 1'b1);
        // The largest local time restarts the window; a step back from it
        // looks like a very long interval and restarts it again.
        send_frame(16'h80CF, 32'd1, 40'hFF_FFFF_FFFF, 1'b1);
        send_frame(16'h80D0, 32'd7, 40'hFF_FFFF_FFF0, 1'b1);

        // Window of zero restarts only when the local clock moves; a limit of
        // one lets no gap through.
        wait_drained();
        write_reg(slt_pkg::CFG_WINDOW_LENGTH, 16'd0);
        write_reg(slt_pkg::CFG_GAP_LIMIT, 16'd1);
        settings_used++;
        send_frame(16'h80D2, 32'd100, 40'hFF_FFFF_FFF0, 1'b1);
        send_frame(16'h80D4, 32'd100, 40'hFF_FFFF_FFF1, 1'b0);

        // Widest window and largest limit. The top data bit must be dropped
        // by the 15-bit limit register. The clock wraps past 2^40: exactly the
        // window length passed keeps the window, one more restarts it.
        wait_drained();
        write_reg(slt_pkg::CFG_WINDOW_LENGTH, 16'hFFFF);
        write_reg(slt_pkg::CFG_GAP_LIMIT, 16'hFFFF);
        settings_used++;
        send_frame(16'h80D5, 32'd10, 40'd1000, 1'b1);
        send_frame(16'h00D4, 32'd20, 40'h00_0000_FFF0, 1'b1);
        send_frame(16'h80D4, 32'd20, 40'h00_0000_FFF1, 1'b0);

        // A limit of zero: even a single lost frame is not counted.
        wait_drained();
        write_reg(slt_pkg::CFG_WINDOW_LENGTH, 16'd1);
        write_reg(slt_pkg::CFG_GAP_LIMIT, 16'd0);
        settings_used++;
        send_frame(16'h80D6, 32'd30, 40'h01_0000, 1'b1);
        send_frame(16'h80D7, 32'd30, 40'h01_0001, 1'b0);
        send_frame(16'h80D8, 32'd0, 40'h01_0002, 1'b1);

        // Random phases, each with its own register settings and stream.
        // Registers change only once every result of the previous phase is in.
        for (int phase = 0; phase < 10; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    window_data = 16'd10000;
                    gap_data    = 16'd100;
                end
                1: begin
                    window_data = 16'd1;
                    gap_data    = 16'd2;
                end
                2: begin
                    window_data = 16'hFFFF;
                    gap_data    = 16'h7FFF;
                end
                3: begin
                    window_data = 16'd0;
                    gap_data    = 16'd0;
                end
                default: begin
                    window_data = 16'($urandom_range(1, 65535));
                    gap_data    = 16'($urandom);
                end
            endcase
            write_reg(slt_pkg::CFG_WINDOW_LENGTH, window_data);
            write_reg(slt_pkg::CFG_GAP_LIMIT, gap_data);
            settings_used++;
            quiet         = (phase == 4 || phase == 7);
            seq_cursor    = 16'($urandom);
            clock_ms      = 40'({$urandom, $urandom});
            sender_offset = 32'($urandom_range(0, 5000));
            repeat (55) random_frame();
        end
        quiet = 1'b0;

        // Let the last results come out, then give the block some extra
        // cycles to show any result that nobody expects.
        wait_drained();
        repeat (24) @(negedge i_clk);

        $display("Ran %0d frame transactions under %0d register settings, %0d results compared.",
                 frames_sent, settings_used, compared);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, outstanding);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Far beyond the slowest correct run, even with every long stall hit.
    initial begin : watchdog
        #2000000;
        $display("Timed out with %0d results still expected", outstanding);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
